// ----- hw/rtl/sot_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the shape overlap test unit.
// No dependencies; the channel interfaces and the top level take names from here.
package sot_pkg;

	// Shape code carried by probe_round and zone_round.
	localparam logic SHAPE_RECT   = 1'b0;
	localparam logic SHAPE_CIRCLE = 1'b1;

	// Width of the trigger tag that travels with every request.
	localparam int TAG_BITS = 8;

	typedef logic [TAG_BITS-1:0] tag_t;

endpackage

// ----- hw/rtl/sot_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the shape overlap test unit: shape-pair
// requests in, overlap results out. Depends on sot_pkg for the tag type.
interface sot_req_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] probe_x;
	logic signed [COORD_BITS-1:0] probe_y;
	logic        [COORD_BITS-1:0] probe_w;
	logic        [COORD_BITS-1:0] probe_h;
	logic                         probe_round;
	logic signed [COORD_BITS-1:0] zone_x;
	logic signed [COORD_BITS-1:0] zone_y;
	logic        [COORD_BITS-1:0] zone_w;
	logic        [COORD_BITS-1:0] zone_h;
	logic                         zone_round;
	sot_pkg::tag_t                zone_tag;

	modport source (
		output valid, probe_x, probe_y, probe_w, probe_h, probe_round,
		output zone_x, zone_y, zone_w, zone_h, zone_round, zone_tag,
		input  ready
	);
	modport sink (
		input  valid, probe_x, probe_y, probe_w, probe_h, probe_round,
		input  zone_x, zone_y, zone_w, zone_h, zone_round, zone_tag,
		output ready
	);
endinterface

interface sot_rsp_if;
	logic          valid;
	logic          ready;
	logic          overlap;
	sot_pkg::tag_t tag_out;

	modport source (
		output valid, overlap, tag_out,
		input  ready
	);
	modport sink (
		input  valid, overlap, tag_out,
		output ready
	);
endinterface

// ----- hw/rtl/shape_overlap_test_unit.sv -----
`timescale 1ns / 1ps
// Top level of the shape overlap test unit: a four-stage pipeline from request to result.
// Depends on sot_pkg and on the channel interfaces in sot_if.sv.

// Each request pairs a probe shape with one trigger shape and yields exactly one result:
// an overlap flag and the trigger's tag, in request order. The unit takes one request
// every clock cycle unless a stalled output backs up the pipeline. The stages are the
// input register, operand formation, the three parallel squarers and the final add and
// compare. Each stage holds its item until the next one frees, so requests keep flowing
// into empty stages while a result waits.
// Coordinates are signed and sizes unsigned, both COORD_BITS wide; the fraction point
// does not affect any comparison. Circle geometry is worked at twice the input scale,
// so halving the larger side is exact and every square is formed in full.
module shape_overlap_test_unit #(
	parameter int COORD_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	sot_req_if.sink      req,
	sot_rsp_if.source    rsp
);

	localparam int C  = COORD_BITS;
	localparam int W  = COORD_BITS + 4;   // signed working width at doubled scale
	localparam int M  = COORD_BITS + 2;   // magnitude width fed to the squarers
	localparam int SQ = 2 * M;

	typedef logic signed [W-1:0] sw_t;

	// Handshake: a stage loads when it is empty or its successor takes its item.
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	assign rdy_s4    = !v_s4 || rsp.ready;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign req.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= req.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: input register.
	logic signed [C-1:0] px_s1, py_s1, zx_s1, zy_s1;
	logic        [C-1:0] pw_s1, ph_s1, zw_s1, zh_s1;
	logic                pround_s1, zround_s1;
	sot_pkg::tag_t       tag_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && req.valid) begin
			px_s1     <= req.probe_x;
			py_s1     <= req.probe_y;
			pw_s1     <= req.probe_w;
			ph_s1     <= req.probe_h;
			pround_s1 <= req.probe_round;
			zx_s1     <= req.zone_x;
			zy_s1     <= req.zone_y;
			zw_s1     <= req.zone_w;
			zh_s1     <= req.zone_h;
			zround_s1 <= req.zone_round;
			tag_s1    <= req.zone_tag;
		end
	end

	// Operand formation.
	sw_t px, py, pw, ph, zx, zy, zw, zh, pr, zr;
	sw_t pcx, pcy, zcx, zcy;
	sw_t cx, cy, cr, rx, ry, rw, rh, rx_hi, ry_hi, dx, dy, nx, ny;
	sw_t op_a, op_b, op_r, abs_a, abs_b, abs_r;
	logic rr_hit, in_x, in_y, band_x, band_y, cr_hit;
	logic early_hit, use_sq;

	always_comb begin
		px = $signed({{(W-C){px_s1[C-1]}}, px_s1});
		py = $signed({{(W-C){py_s1[C-1]}}, py_s1});
		zx = $signed({{(W-C){zx_s1[C-1]}}, zx_s1});
		zy = $signed({{(W-C){zy_s1[C-1]}}, zy_s1});
		pw = $signed({{(W-C){1'b0}}, pw_s1});
		ph = $signed({{(W-C){1'b0}}, ph_s1});
		zw = $signed({{(W-C){1'b0}}, zw_s1});
		zh = $signed({{(W-C){1'b0}}, zh_s1});

		// Radius at doubled scale is the larger side; centre is corner plus radius.
		pr  = (pw_s1 > ph_s1) ? pw : ph;
		zr  = (zw_s1 > zh_s1) ? zw : zh;
		pcx = px + px + pr;
		pcy = py + py + pr;
		zcx = zx + zx + zr;
		zcy = zy + zy + zr;

		rr_hit = (px + pw > zx) && (px < zx + zw) && (py < zy + zh) && (py + ph > zy);

		// The single circle-against-rectangle datapath takes whichever shape is round.
		if (zround_s1 == sot_pkg::SHAPE_CIRCLE && pround_s1 == sot_pkg::SHAPE_RECT) begin
			cx = zcx;
			cy = zcy;
			cr = zr;
			rx = px + px;
			ry = py + py;
			rw = pw;
			rh = ph;
		end else begin
			cx = pcx;
			cy = pcy;
			cr = pr;
			rx = zx + zx;
			ry = zy + zy;
			rw = zw;
			rh = zh;
		end
		rx_hi = rx + rw + rw;
		ry_hi = ry + rh + rh;
		dx    = rx + rw - cx;
		dy    = ry + rh - cy;
		in_x  = (cx <= rx_hi) && (cx >= rx);
		in_y  = (cy <= ry_hi) && (cy >= ry);
		// A centre exactly on the middle counts as the low side.
		band_x = !dx[W-1] ? (cx + cr >= rx) : (cx - cr < rx_hi);
		band_y = !dy[W-1] ? (cy + cr >= ry) : (cy - cr < ry_hi);
		// Offset from the centre to the nearest edge on each axis.
		nx     = !dx[W-1] ? (rx - cx) : (rx_hi - cx);
		ny     = !dy[W-1] ? (ry - cy) : (ry_hi - cy);
		cr_hit = (band_x && in_y) || (band_y && in_x);

		if (pround_s1 == sot_pkg::SHAPE_RECT && zround_s1 == sot_pkg::SHAPE_RECT) begin
			early_hit = rr_hit;
			use_sq    = 1'b0;
			op_a      = nx;
			op_b      = ny;
			op_r      = cr;
		end else if (pround_s1 == sot_pkg::SHAPE_CIRCLE &&
			     zround_s1 == sot_pkg::SHAPE_CIRCLE) begin
			early_hit = 1'b0;
			use_sq    = 1'b1;
			op_a      = pcx - zcx;
			op_b      = pcy - zcy;
			op_r      = pr + zr;
		end else begin
			early_hit = cr_hit;
			use_sq    = !cr_hit;
			op_a      = nx;
			op_b      = ny;
			op_r      = cr;
		end

		abs_a = op_a[W-1] ? -op_a : op_a;
		abs_b = op_b[W-1] ? -op_b : op_b;
		abs_r = op_r[W-1] ? -op_r : op_r;
	end

	// Stage 2: magnitudes and early decision.
	logic [M-1:0]  mag_a_s2, mag_b_s2, mag_r_s2;
	logic          early_s2, use_sq_s2;
	sot_pkg::tag_t tag_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			mag_a_s2  <= abs_a[M-1:0];
			mag_b_s2  <= abs_b[M-1:0];
			mag_r_s2  <= abs_r[M-1:0];
			early_s2  <= early_hit;
			use_sq_s2 <= use_sq;
			tag_s2    <= tag_s1;
		end
	end

	// Stage 3: three squarers in parallel.
	logic [SQ-1:0] sq_a_s3, sq_b_s3, sq_r_s3;
	logic          early_s3, use_sq_s3;
	sot_pkg::tag_t tag_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			sq_a_s3   <= mag_a_s2 * mag_a_s2;
			sq_b_s3   <= mag_b_s2 * mag_b_s2;
			sq_r_s3   <= mag_r_s2 * mag_r_s2;
			early_s3  <= early_s2;
			use_sq_s3 <= use_sq_s2;
			tag_s3    <= tag_s2;
		end
	end

	// Stage 4: sum of squares against the squared radius, or the early decision, into the result register.
	logic [SQ:0]   sq_sum;
	logic          hit;
	logic          overlap_s4;
	sot_pkg::tag_t tag_s4;

	assign sq_sum = {1'b0, sq_a_s3} + {1'b0, sq_b_s3};
	assign hit    = early_s3 || (use_sq_s3 && (sq_sum < {1'b0, sq_r_s3}));

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			overlap_s4 <= hit;
			tag_s4     <= tag_s3;
		end
	end

	assign rsp.valid   = v_s4;
	assign rsp.overlap = overlap_s4;
	assign rsp.tag_out = tag_s4;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the shape overlap test unit: a directed table, then random shape pairs.
// Depends on sot_pkg, on the channel interfaces in sot_if.sv and on shape_overlap_test_unit.
module tb;

	localparam int COORD_BITS   = 16;
	localparam int RESET_CYCLES = 12;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 16;
	localparam int QUIET_LIMIT  = 5000;
	localparam int MAX_REPORTS  = 100;

	localparam logic SHAPE_RECT   = sot_pkg::SHAPE_RECT;
	localparam logic SHAPE_CIRCLE = sot_pkg::SHAPE_CIRCLE;

	typedef sot_pkg::tag_t tag_t;
	typedef logic signed [COORD_BITS-1:0] scoord_t;
	typedef logic        [COORD_BITS-1:0] extent_t;

	typedef struct {
		scoord_t probe_x;
		scoord_t probe_y;
		extent_t probe_w;
		extent_t probe_h;
		logic    probe_round;
		scoord_t zone_x;
		scoord_t zone_y;
		extent_t zone_w;
		extent_t zone_h;
		logic    zone_round;
		tag_t    zone_tag;
	} shape_pair_t;

	typedef struct {
		logic overlap;
		tag_t tag;
	} hit_result_t;

	typedef struct {
		shape_pair_t pair;
		bit          known;
		logic        known_hit;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sot_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
	sot_rsp_if rsp_ch ();

	shape_overlap_test_unit #(.COORD_BITS(COORD_BITS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	hit_result_t awaited_results[$];
	table_row_t  shape_table[$];
	int          mismatch_count = 0;
	int          req_idle_pct   = 24;
	int          rsp_idle_pct   = 24;
	int          holds_asked    = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t mismatch: %s", $realtime, what);
	endtask

	// Circle at doubled scale against a box whose corner is at doubled scale and whose
	// sizes are plain, so that the box middle is corner plus size.
	function automatic logic circle_meets_box(input longint cx, cy, r, bx, by, w, h);
		longint dx, dy, fw, fh;
		logic   in_x, in_y, band_x, band_y;
		fw = 2 * w;
		fh = 2 * h;
		dx = bx + w - cx;
		dy = by + h - cy;
		in_y = (cy <= by + fh) && (cy >= by);
		in_x = (cx <= bx + fw) && (cx >= bx);
		// Reaching the low edge counts as contact; the high edge must be crossed.
		band_x = (dx >= 0) ? (cx + r >= bx) : (cx - r < bx + fw);
		band_y = (dy >= 0) ? (cy + r >= by) : (cy - r < by + fh);
		if ((band_x && in_y) || (band_y && in_x))
			return 1'b1;
		dx = (dx >= 0) ? dx - w : dx + w;
		dy = (dy >= 0) ? dy - h : dy + h;
		return (dx * dx + dy * dy) < (r * r);
	endfunction

	function automatic logic shapes_overlap(input shape_pair_t p);
		longint px, py, pw, ph, zx, zy, zw, zh, pr, zr, pcx, pcy, zcx, zcy;
		px = longint'(p.probe_x);
		py = longint'(p.probe_y);
		pw = longint'(p.probe_w);
		ph = longint'(p.probe_h);
		zx = longint'(p.zone_x);
		zy = longint'(p.zone_y);
		zw = longint'(p.zone_w);
		zh = longint'(p.zone_h);
		pr = (pw > ph) ? pw : ph;
		zr = (zw > zh) ? zw : zh;
		pcx = 2 * px + pr;
		pcy = 2 * py + pr;
		zcx = 2 * zx + zr;
		zcy = 2 * zy + zr;
		if (p.probe_round == SHAPE_RECT && p.zone_round == SHAPE_RECT)
			return (px + pw > zx) && (px < zx + zw) && (py < zy + zh) && (py + ph > zy);
		else if (p.zone_round == SHAPE_RECT)
			return circle_meets_box(pcx, pcy, pr, 2 * zx, 2 * zy, zw, zh);
		else if (p.probe_round == SHAPE_RECT)
			return circle_meets_box(zcx, zcy, zr, 2 * px, 2 * py, pw, ph);
		return ((pcx - zcx) * (pcx - zcx) + (pcy - zcy) * (pcy - zcy)) < ((pr + zr) * (pr + zr));
	endfunction

	function automatic shape_pair_t make_pair(input int px, py, pw, ph, input logic pround,
			input int zx, zy, zw, zh, input logic zround, input int tag);
		shape_pair_t p;
		p.probe_x     = scoord_t'(px);
		p.probe_y     = scoord_t'(py);
		p.probe_w     = extent_t'(pw);
		p.probe_h     = extent_t'(ph);
		p.probe_round = pround;
		p.zone_x      = scoord_t'(zx);
		p.zone_y      = scoord_t'(zy);
		p.zone_w      = extent_t'(zw);
		p.zone_h      = extent_t'(zh);
		p.zone_round  = zround;
		p.zone_tag    = tag_t'(tag);
		return p;
	endfunction

	function automatic void add_row(input shape_pair_t p, input bit known, input logic hit);
		table_row_t row;
		row.pair      = p;
		row.known     = known;
		row.known_hit = hit;
		shape_table.push_back(row);
	endfunction

	// Mostly neighbouring shapes of modest size so that hits and misses both occur often;
	// the rest is fully random over every field.
	function automatic shape_pair_t random_pair();
		shape_pair_t p;
		int          span;
		p.probe_round = ($urandom_range(1) == 1) ? SHAPE_CIRCLE : SHAPE_RECT;
		p.zone_round  = ($urandom_range(1) == 1) ? SHAPE_CIRCLE : SHAPE_RECT;
		p.zone_tag    = tag_t'($urandom);
		p.probe_x     = scoord_t'($urandom);
		p.probe_y     = scoord_t'($urandom);
		if ($urandom_range(9) < 2) begin
			p.probe_w = extent_t'($urandom);
			p.probe_h = extent_t'($urandom);
			p.zone_x  = scoord_t'($urandom);
			p.zone_y  = scoord_t'($urandom);
			p.zone_w  = extent_t'($urandom);
			p.zone_h  = extent_t'($urandom);
		end else begin
			span = ($urandom_range(7) == 0) ? 65535 : 255;
			p.probe_w = extent_t'($urandom_range(span));
			p.probe_h = extent_t'($urandom_range(span));
			p.zone_w  = extent_t'($urandom_range(span));
			p.zone_h  = extent_t'($urandom_range(span));
			p.zone_x  = scoord_t'(int'(p.probe_x) + int'($urandom_range(600)) - 300);
			p.zone_y  = scoord_t'(int'(p.probe_y) + int'($urandom_range(600)) - 300);
		end
		return p;
	endfunction

	// Entered and left at a falling edge, so valid gets one assignment per time step.
	task automatic send_request(input shape_pair_t p, input bit known, input logic known_hit);
		hit_result_t want;
		while ($urandom_range(99) < req_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.probe_x     <= p.probe_x;
		req_ch.probe_y     <= p.probe_y;
		req_ch.probe_w     <= p.probe_w;
		req_ch.probe_h     <= p.probe_h;
		req_ch.probe_round <= p.probe_round;
		req_ch.zone_x      <= p.zone_x;
		req_ch.zone_y      <= p.zone_y;
		req_ch.zone_w      <= p.zone_w;
		req_ch.zone_h      <= p.zone_h;
		req_ch.zone_round  <= p.zone_round;
		req_ch.zone_tag    <= p.zone_tag;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		want.overlap = known ? known_hit : shapes_overlap(p);
		want.tag     = p.zone_tag;
		awaited_results.push_back(want);
		@(negedge clk);
	endtask

	initial begin : result_sink
		hit_result_t want;
		int          holds_done;
		int          hold_left;
		holds_done   = 0;
		hold_left    = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("result with no request pending, tag %0d",
						rsp_ch.tag_out));
				end else begin
					want = awaited_results.pop_front();
					if (rsp_ch.overlap !== want.overlap)
						report_mismatch($sformatf("tag %0d overlap %b, expected %b",
							want.tag, rsp_ch.overlap, want.overlap));
					if (rsp_ch.tag_out !== want.tag)
						report_mismatch($sformatf("tag_out %0d, expected %0d",
							rsp_ch.tag_out, want.tag));
				end
			end
			@(negedge clk);
			if (holds_done != holds_asked) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
					(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.probe_x     = '0;
		req_ch.probe_y     = '0;
		req_ch.probe_w     = '0;
		req_ch.probe_h     = '0;
		req_ch.probe_round = SHAPE_RECT;
		req_ch.zone_x      = '0;
		req_ch.zone_y      = '0;
		req_ch.zone_w      = '0;
		req_ch.zone_h      = '0;
		req_ch.zone_round  = SHAPE_RECT;
		req_ch.zone_tag    = '0;

		// Boxes: overlap, shared edge, zero size, full range apart and just touching inside.
		add_row(make_pair(0, 0, 16, 16, SHAPE_RECT, 8, 8, 16, 16, SHAPE_RECT, 1), 1'b1, 1'b1);
		add_row(make_pair(0, 0, 16, 16, SHAPE_RECT, 16, 0, 16, 16, SHAPE_RECT, 2), 1'b1, 1'b0);
		add_row(make_pair(5, 5, 0, 0, SHAPE_RECT, 5, 5, 0, 0, SHAPE_RECT, 3), 1'b1, 1'b0);
		add_row(make_pair(-32768, -32768, 65535, 65535, SHAPE_RECT,
			32767, 32767, 65535, 65535, SHAPE_RECT, 255), 1'b1, 1'b0);
		add_row(make_pair(-32768, -32768, 65535, 65535, SHAPE_RECT,
			32766, 32766, 1, 1, SHAPE_RECT, 0), 1'b1, 1'b1);
		// Circles: zero radius, overlap, exact touch, extremes.
		add_row(make_pair(0, 0, 0, 0, SHAPE_CIRCLE, 0, 0, 0, 0, SHAPE_CIRCLE, 4), 1'b1, 1'b0);
		add_row(make_pair(0, 0, 32, 32, SHAPE_CIRCLE, 16, 0, 32, 32, SHAPE_CIRCLE, 5),
			1'b1, 1'b1);
		add_row(make_pair(0, 0, 32, 32, SHAPE_CIRCLE, 32, 0, 32, 32, SHAPE_CIRCLE, 6),
			1'b1, 1'b0);
		add_row(make_pair(-32768, -32768, 65535, 65535, SHAPE_CIRCLE,
			32767, 32767, 65535, 65535, SHAPE_CIRCLE, 7), 1'b0, 1'b0);
		add_row(make_pair(32767, 32767, 65535, 65535, SHAPE_CIRCLE,
			32767, 32767, 65535, 65535, SHAPE_CIRCLE, 8), 1'b0, 1'b0);
		// Circle against box: centre at the middle, band edges on each side, corner either side.
		add_row(make_pair(0, 0, 16, 16, SHAPE_CIRCLE, 0, 0, 16, 16, SHAPE_RECT, 9), 1'b0, 1'b0);
		add_row(make_pair(0, 0, 16, 16, SHAPE_CIRCLE, 16, 0, 16, 16, SHAPE_RECT, 10),
			1'b0, 1'b0);
		add_row(make_pair(0, 0, 16, 16, SHAPE_CIRCLE, -16, 0, 16, 16, SHAPE_RECT, 11),
			1'b0, 1'b0);
		add_row(make_pair(0, 0, 16, 16, SHAPE_CIRCLE, 0, 16, 16, 16, SHAPE_RECT, 12),
			1'b0, 1'b0);
		add_row(make_pair(0, 0, 16, 16, SHAPE_CIRCLE, 0, -16, 16, 16, SHAPE_RECT, 13),
			1'b0, 1'b0);
		add_row(make_pair(0, 0, 32, 32, SHAPE_CIRCLE, 27, 27, 16, 16, SHAPE_RECT, 14),
			1'b0, 1'b0);
		add_row(make_pair(0, 0, 32, 32, SHAPE_CIRCLE, 28, 28, 16, 16, SHAPE_RECT, 15),
			1'b0, 1'b0);
		add_row(make_pair(0, 0, 48, 8, SHAPE_CIRCLE, 40, 0, 8, 8, SHAPE_RECT, 16), 1'b0, 1'b0);
		// Box probe against circle trigger, including zero sizes on either side, then one more circle pair.
		add_row(make_pair(0, 0, 16, 16, SHAPE_RECT, 8, 8, 16, 16, SHAPE_CIRCLE, 17), 1'b0, 1'b0);
		add_row(make_pair(0, 0, 16, 16, SHAPE_RECT, 4, 4, 0, 0, SHAPE_CIRCLE, 18), 1'b0, 1'b0);
		add_row(make_pair(10, 10, 0, 0, SHAPE_RECT, 0, 0, 40, 40, SHAPE_CIRCLE, 19), 1'b0, 1'b0);
		add_row(make_pair(-100, -50, 30, 20, SHAPE_CIRCLE, -120, -60, 10, 10, SHAPE_CIRCLE, 20),
			1'b0, 1'b0);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (shape_table[i])
			send_request(shape_table[i].pair, shape_table[i].known, shape_table[i].known_hit);
		repeat (400) send_request(random_pair(), 1'b0, 1'b0);

		// Let the pipeline drain completely before the next request.
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (awaited_results.size() != 0);

		req_idle_pct = 0;
		rsp_idle_pct = 0;
		repeat (300) send_request(random_pair(), 1'b0, 1'b0);
		// The result side holds off while requests keep coming, so the unit backs up.
		holds_asked++;
		repeat (100) send_request(random_pair(), 1'b0, 1'b0);

		req_idle_pct = 24;
		rsp_idle_pct = 24;
		repeat (400) send_request(random_pair(), 1'b0, 1'b0);
		req_ch.valid <= 1'b0;

		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && awaited_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
